// ----- sv/cmw_pkg.sv -----
// Shared types and constants for the CAN motor command watchdog.
package cmw_pkg;

	localparam int KIND_W      = 2;
	localparam int FRAME_ID_W  = 11;
	localparam int BYTE_W      = 8;
	localparam int DUTY_W      = 16;
	localparam int ACTION_W    = 2;
	localparam int PERIOD_W    = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FRAME   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MOTOR_O = 2'd2;
	localparam logic [KIND_W-1:0] KIND_LED_O   = 2'd3;

	// Motor actions.
	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SET  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_FREE = 2'd2;

	// Register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_ID     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FREE_ID     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_IVL     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LED_PRESENT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_LED_LINKED  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_LED_LOST    = 3'd5;

	// Register reset values.
	localparam logic [FRAME_ID_W-1:0] RST_DUTY_ID    = 11'd0;
	localparam logic [FRAME_ID_W-1:0] RST_FREE_ID    = 11'd1;
	localparam logic [PERIOD_W-1:0]   RST_MAX_IVL    = 16'd100;
	localparam logic                  RST_LED_PRES   = 1'b0;
	localparam logic [PERIOD_W-1:0]   RST_LED_LINKED = 16'd500;
	localparam logic [PERIOD_W-1:0]   RST_LED_LOST   = 16'd100;

	typedef struct packed {
		logic [FRAME_ID_W-1:0] duty_frame_id;
		logic [FRAME_ID_W-1:0] free_frame_id;
		logic [PERIOD_W-1:0]   link_timeout;
		logic                  led_present;
		logic [PERIOD_W-1:0]   led_period_linked;
		logic [PERIOD_W-1:0]   led_period_lost;
	} cfg_t;

endpackage

// ----- sv/cmw_cfg_regs.sv -----
// Configuration register file of the CAN motor command watchdog.
module cmw_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cmw_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [cmw_pkg::CFG_DATA_W-1:0]      cfg_data,
	output cmw_pkg::cfg_t                       cfg
);

	cmw_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty_frame_id     <= cmw_pkg::RST_DUTY_ID;
			cfg_q.free_frame_id     <= cmw_pkg::RST_FREE_ID;
			cfg_q.link_timeout      <= cmw_pkg::RST_MAX_IVL;
			cfg_q.led_present       <= cmw_pkg::RST_LED_PRES;
			cfg_q.led_period_linked <= cmw_pkg::RST_LED_LINKED;
			cfg_q.led_period_lost   <= cmw_pkg::RST_LED_LOST;
		end else if (cfg_we) begin
			case (cfg_index)
				cmw_pkg::REG_DUTY_ID: begin
					cfg_q.duty_frame_id <= cfg_data[cmw_pkg::FRAME_ID_W-1:0];
				end
				cmw_pkg::REG_FREE_ID: begin
					cfg_q.free_frame_id <= cfg_data[cmw_pkg::FRAME_ID_W-1:0];
				end
				cmw_pkg::REG_MAX_IVL: begin
					cfg_q.link_timeout <= cfg_data[cmw_pkg::PERIOD_W-1:0];
				end
				cmw_pkg::REG_LED_PRESENT: begin
					cfg_q.led_present <= cfg_data[0];
				end
				cmw_pkg::REG_LED_LINKED: begin
					cfg_q.led_period_linked <= cfg_data[cmw_pkg::PERIOD_W-1:0];
				end
				cmw_pkg::REG_LED_LOST: begin
					cfg_q.led_period_lost <= cfg_data[cmw_pkg::PERIOD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/can_motor_command_watchdog_unit.sv -----
// Top level of the CAN motor command watchdog: item pipeline, state and result register.
//
// Usage: each input item (kind, frame_id, data_low, data_high, override_on) is
// one of a 1 ms tick, a received CAN frame, a motor override command or an LED
// override command, offered on in_valid/in_ready. Every item yields exactly one
// result item (motor_action, duty, led_on, link_lost) on out_valid/out_ready.
// Items enter an input register; as soon as the result register is empty or is
// being taken, a single pass of compares, a sign-magnitude duty decode and the
// time subtractions updates the watchdog state and loads the result register,
// which drives out_valid. One item is taken every cycle as long as the receiver
// takes results. The critical path is set by the TIME_BITS-wide increment,
// modular subtract and compare on the timer registers.
// When the receiver stalls, the result register holds its item and the input
// register fills; in_ready falls only when both are occupied.
// Configuration is a write-only port (cfg_we, cfg_index, cfg_data), taken at
// a clock edge with cfg_we high; indexes beyond the register list are ignored.
// Write it only while no item is in flight.
// Reset clears time, last-receive time, LED deadline, LED level and both
// overrides, loads the register defaults and empties the pipeline.
module can_motor_command_watchdog_unit #(
	parameter int TIME_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration port.
	input  logic                                cfg_we,
	input  logic [cmw_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [cmw_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Input channel.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [cmw_pkg::KIND_W-1:0]          kind,
	input  logic [cmw_pkg::FRAME_ID_W-1:0]      frame_id,
	input  logic [cmw_pkg::BYTE_W-1:0]          data_low,
	input  logic [cmw_pkg::BYTE_W-1:0]          data_high,
	input  logic                                override_on,
	// Result channel.
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cmw_pkg::ACTION_W-1:0]        motor_action,
	output logic signed [cmw_pkg::DUTY_W-1:0]   duty,
	output logic                                led_on,
	output logic                                link_lost
);

	cmw_pkg::cfg_t cfg;

	cmw_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register.
	logic                               valid_s1;
	logic [cmw_pkg::KIND_W-1:0]         kind_s1;
	logic [cmw_pkg::FRAME_ID_W-1:0]     frame_id_s1;
	logic [cmw_pkg::BYTE_W-1:0]         data_low_s1;
	logic [cmw_pkg::BYTE_W-1:0]         data_high_s1;
	logic                               override_on_s1;

	// Watchdog state.
	logic [TIME_BITS-1:0] time_now_q;
	logic [TIME_BITS-1:0] last_rx_q;
	logic [TIME_BITS-1:0] led_deadline_q;
	logic                 led_level_q;
	logic                 motor_ovr_q;
	logic                 led_ovr_q;

	// Result register.
	logic                             out_valid_q;
	logic [cmw_pkg::ACTION_W-1:0]     action_q;
	logic [cmw_pkg::DUTY_W-1:0]       duty_q;
	logic                             led_on_q;
	logic                             link_lost_q;

	logic advance;
	logic in_fire;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	// Single-pass item processing.
	logic                          is_tick;
	logic                          is_duty;
	logic                          is_free;
	logic                          refresh;
	logic [TIME_BITS-1:0]          time_eff;
	logic [TIME_BITS-1:0]          silence;
	logic                          lost_cur;
	logic [TIME_BITS-1:0]          dl_diff;
	logic                          dl_passed;
	logic                          led_toggle;
	logic [cmw_pkg::DUTY_W-1:0]    mag;
	logic [cmw_pkg::DUTY_W-1:0]    duty_dec;
	logic [cmw_pkg::PERIOD_W-1:0]  led_period;
	logic [TIME_BITS-1:0]          last_rx_d;
	logic [TIME_BITS-1:0]          led_deadline_d;
	logic                          led_level_d;
	logic                          motor_ovr_d;
	logic                          led_ovr_d;
	logic [cmw_pkg::ACTION_W-1:0]  action_d;
	logic [cmw_pkg::DUTY_W-1:0]    duty_d;
	logic                          lost_d;

	always_comb begin
		is_tick  = (kind_s1 == cmw_pkg::KIND_TICK);
		is_duty  = (kind_s1 == cmw_pkg::KIND_FRAME) && (frame_id_s1 == cfg.duty_frame_id);
		is_free  = (kind_s1 == cmw_pkg::KIND_FRAME) && !is_duty
			&& (frame_id_s1 == cfg.free_frame_id);
		refresh  = is_duty || is_free;

		time_eff = is_tick ? (time_now_q + TIME_BITS'(1)) : time_now_q;
		silence  = time_eff - last_rx_q;
		lost_cur = (silence > TIME_BITS'(cfg.link_timeout));

		// The deadline has passed when the modular distance is nonzero and in the lower half.
		dl_diff    = time_eff - led_deadline_q;
		dl_passed  = (dl_diff != '0) && !dl_diff[TIME_BITS-1];
		led_toggle = is_tick && cfg.led_present && !led_ovr_q && dl_passed;
		led_period = lost_cur ? cfg.led_period_lost : cfg.led_period_linked;

		// Sign and 15-bit magnitude; a negative zero comes out as zero.
		mag      = {1'b0, data_high_s1[6:0], data_low_s1};
		duty_dec = data_high_s1[7] ? (cmw_pkg::DUTY_W'(0) - mag) : mag;

		last_rx_d      = refresh ? time_now_q : last_rx_q;
		led_deadline_d = led_toggle ? (time_eff + TIME_BITS'(led_period)) : led_deadline_q;
		led_level_d    = led_level_q ^ led_toggle;
		motor_ovr_d    = motor_ovr_q;
		led_ovr_d      = led_ovr_q;
		action_d       = cmw_pkg::ACT_NONE;
		duty_d         = '0;

		case (kind_s1)
			cmw_pkg::KIND_TICK: begin
				if (lost_cur && !motor_ovr_q) begin
					action_d = cmw_pkg::ACT_SET;
				end
			end
			cmw_pkg::KIND_FRAME: begin
				if (!motor_ovr_q) begin
					if (is_duty) begin
						action_d = cmw_pkg::ACT_SET;
						duty_d   = duty_dec;
					end else if (is_free) begin
						action_d = cmw_pkg::ACT_FREE;
					end
				end
			end
			cmw_pkg::KIND_MOTOR_O: begin
				if (override_on_s1) begin
					motor_ovr_d = 1'b1;
				end else begin
					motor_ovr_d = 1'b0;
					action_d    = cmw_pkg::ACT_FREE;
				end
			end
			cmw_pkg::KIND_LED_O: begin
				if (override_on_s1) begin
					if (cfg.led_present) begin
						led_ovr_d = 1'b1;
					end
				end else begin
					led_ovr_d = 1'b0;
				end
			end
			default: begin
			end
		endcase

		// A refreshing frame leaves zero silence, which is never over the limit.
		lost_d = refresh ? 1'b0 : lost_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1        <= kind;
			frame_id_s1    <= frame_id;
			data_low_s1    <= data_low;
			data_high_s1   <= data_high;
			override_on_s1 <= override_on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_now_q     <= '0;
			last_rx_q      <= '0;
			led_deadline_q <= '0;
			led_level_q    <= 1'b0;
			motor_ovr_q    <= 1'b0;
			led_ovr_q      <= 1'b0;
		end else if (advance) begin
			time_now_q     <= time_eff;
			last_rx_q      <= last_rx_d;
			led_deadline_q <= led_deadline_d;
			led_level_q    <= led_level_d;
			motor_ovr_q    <= motor_ovr_d;
			led_ovr_q      <= led_ovr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q    <= action_d;
			duty_q      <= duty_d;
			led_on_q    <= led_level_d;
			link_lost_q <= lost_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign motor_action = action_q;
	assign duty         = duty_q;
	assign led_on       = led_on_q;
	assign link_lost    = link_lost_q;

	// A nonzero duty only ever comes with a set-duty action.
	a_duty_only_on_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (duty_q != '0) |-> (action_q == cmw_pkg::ACT_SET))
		else $error("nonzero duty without set-duty action");

	// Releasing the motor override clears it and commands free.
	a_release_frees: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (kind_s1 == cmw_pkg::KIND_MOTOR_O) && !override_on_s1
		|=> !motor_ovr_q && (action_q == cmw_pkg::ACT_FREE))
		else $error("motor override release did not command free");

	// No frame reaches the motor while it is overridden.
	a_override_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		advance && motor_ovr_q && (kind_s1 == cmw_pkg::KIND_FRAME)
		|=> (action_q == cmw_pkg::ACT_NONE))
		else $error("frame command passed during motor override");

	// An item waiting in the input register is neither dropped nor replaced.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(kind_s1) && $stable(frame_id_s1))
		else $error("stalled input stage lost its item");

	// Time only moves on a tick.
	a_time_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && is_tick) |=> $stable(time_now_q))
		else $error("time advanced without a tick");

endmodule

// ----- dv/tb_can_motor_command_watchdog_unit.sv -----
// Self-checking testbench for the CAN motor command watchdog unit.
`timescale 1ns / 1ps

// Tracks the watchdog state and the expected motor commands, and checks the results against them.
class motor_cmd_scoreboard #(int TIME_BITS = 32);

	typedef struct packed {
		logic [cmw_pkg::ACTION_W-1:0]      action;
		logic signed [cmw_pkg::DUTY_W-1:0] duty;
		logic                              led;
		logic                              lost;
	} command_t;

	cmw_pkg::cfg_t      regs;
	bit [TIME_BITS-1:0] now_ms;
	bit [TIME_BITS-1:0] last_rx_ms;
	bit [TIME_BITS-1:0] led_due;
	bit                 led_level;
	bit                 motor_held;
	bit                 led_held;
	command_t           predicted[$];
	int                 errors;

	function new();
		regs = '{duty_frame_id: cmw_pkg::RST_DUTY_ID, free_frame_id: cmw_pkg::RST_FREE_ID,
			link_timeout: cmw_pkg::RST_MAX_IVL, led_present: cmw_pkg::RST_LED_PRES,
			led_period_linked: cmw_pkg::RST_LED_LINKED, led_period_lost: cmw_pkg::RST_LED_LOST};
		now_ms = '0;
		last_rx_ms = '0;
		led_due = '0;
		led_level = 1'b0;
		motor_held = 1'b0;
		led_held = 1'b0;
		errors = 0;
	endfunction

	function void write_reg(logic [cmw_pkg::CFG_INDEX_W-1:0] index,
			logic [cmw_pkg::CFG_DATA_W-1:0] data);
		case (index)
			cmw_pkg::REG_DUTY_ID:     regs.duty_frame_id = data[cmw_pkg::FRAME_ID_W-1:0];
			cmw_pkg::REG_FREE_ID:     regs.free_frame_id = data[cmw_pkg::FRAME_ID_W-1:0];
			cmw_pkg::REG_MAX_IVL:     regs.link_timeout = data;
			cmw_pkg::REG_LED_PRESENT: regs.led_present = data[0];
			cmw_pkg::REG_LED_LINKED:  regs.led_period_linked = data;
			cmw_pkg::REG_LED_LOST:    regs.led_period_lost = data;
			default: ;
		endcase
	endfunction

	// The silence is taken modulo the timer width, so it survives a wrap of the time base.
	function bit link_silent();
		bit [TIME_BITS-1:0] gap;
		gap = now_ms - last_rx_ms;
		return gap > regs.link_timeout;
	endfunction

	function void note_item(logic [cmw_pkg::KIND_W-1:0] kind, logic [cmw_pkg::FRAME_ID_W-1:0] fid,
			logic [cmw_pkg::BYTE_W-1:0] lo, logic [cmw_pkg::BYTE_W-1:0] hi, logic on);
		command_t           cmd;
		bit                 lost;
		bit [TIME_BITS-1:0] since_due;
		logic [15:0]        mag;
		cmd = '{action: cmw_pkg::ACT_NONE, duty: '0, led: 1'b0, lost: 1'b0};
		case (kind)
			cmw_pkg::KIND_TICK: begin
				now_ms = now_ms + 1'b1;
				lost = link_silent();
				if (lost && !motor_held)
					cmd.action = cmw_pkg::ACT_SET;
				// The deadline has passed when the modular distance is nonzero and in the lower half.
				since_due = now_ms - led_due;
				if (regs.led_present && !led_held && since_due != '0 && !since_due[TIME_BITS-1]) begin
					led_level = ~led_level;
					led_due = now_ms + (lost ? regs.led_period_lost : regs.led_period_linked);
				end
			end
			cmw_pkg::KIND_FRAME: begin
				if (fid == regs.duty_frame_id) begin
					mag = {1'b0, hi[6:0], lo};
					if (hi[7])
						mag = -mag;
					if (!motor_held) begin
						cmd.action = cmw_pkg::ACT_SET;
						cmd.duty = mag;
					end
					last_rx_ms = now_ms;
				end else if (fid == regs.free_frame_id) begin
					if (!motor_held)
						cmd.action = cmw_pkg::ACT_FREE;
					last_rx_ms = now_ms;
				end
			end
			cmw_pkg::KIND_MOTOR_O: begin
				if (on) begin
					motor_held = 1'b1;
				end else begin
					motor_held = 1'b0;
					cmd.action = cmw_pkg::ACT_FREE;
				end
			end
			default: begin
				if (on) begin
					if (regs.led_present)
						led_held = 1'b1;
				end else begin
					led_held = 1'b0;
				end
			end
		endcase
		cmd.led = led_level;
		cmd.lost = link_silent();
		predicted.push_back(cmd);
	endfunction

	function void report(string field, longint want, longint got);
		errors++;
		$error("%s: expected %0d, got %0d", field, want, got);
	endfunction

	function void check_command(logic [cmw_pkg::ACTION_W-1:0] action,
			logic signed [cmw_pkg::DUTY_W-1:0] duty, logic led, logic lost);
		command_t want;
		if (predicted.size() == 0) begin
			errors++;
			$error("result with no command pending: motor_action %0d, duty %0d",
				action, duty);
			return;
		end
		want = predicted.pop_front();
		if (action !== want.action)
			report("motor_action", want.action, action);
		if (duty !== want.duty)
			report("duty", $signed(want.duty), duty);
		if (led !== want.led)
			report("led_on", want.led, led);
		if (lost !== want.lost)
			report("link_lost", want.lost, lost);
	endfunction

	function int pending();
		return predicted.size();
	endfunction

endclass

module tb_can_motor_command_watchdog_unit;

	localparam int TIME_BITS   = 32;
	// Cycles without any accepted item before the run is declared hung.
	localparam int QUIET_LIMIT = 5000;
	// Random items per configuration segment; six segments give about 2000 items.
	localparam int PHASE_ITEMS = 330;

	localparam int KIND_W      = cmw_pkg::KIND_W;
	localparam int FRAME_ID_W  = cmw_pkg::FRAME_ID_W;
	localparam int BYTE_W      = cmw_pkg::BYTE_W;
	localparam int DUTY_W      = cmw_pkg::DUTY_W;
	localparam int ACTION_W    = cmw_pkg::ACTION_W;
	localparam int PERIOD_W    = cmw_pkg::PERIOD_W;
	localparam int CFG_INDEX_W = cmw_pkg::CFG_INDEX_W;
	localparam int CFG_DATA_W  = cmw_pkg::CFG_DATA_W;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]         cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [KIND_W-1:0]             kind = cmw_pkg::KIND_TICK;
	logic [FRAME_ID_W-1:0]         frame_id = '0;
	logic [BYTE_W-1:0]             data_low = '0;
	logic [BYTE_W-1:0]             data_high = '0;
	logic                          override_on = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [ACTION_W-1:0]           motor_action;
	logic signed [DUTY_W-1:0]      duty;
	logic                          led_on;
	logic                          link_lost;

	// Percent of cycles in which the sender idles or the receiver stalls.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	motor_cmd_scoreboard #(TIME_BITS) sb;

	can_motor_command_watchdog_unit #(.TIME_BITS(TIME_BITS)) dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// The receiver stalls at random, one decision per cycle.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Handshakes are sampled at the clock edge, so both sides see the values from before the edge.
	// An accepted input item is noted before any result of the same edge is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_item(kind, frame_id, data_low, data_high, override_on);
			if (out_valid && out_ready)
				sb.check_command(motor_action, duty, led_on, link_lost);
		end
	end

	// The run is declared hung when no item moves on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT)
				break;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Offers one item and returns at the edge where it is accepted. The sender may first idle,
	// deciding at random at each edge to hold valid low; otherwise valid stays high straight from the previous item.
	task automatic push_item(logic [KIND_W-1:0] k, logic [FRAME_ID_W-1:0] fid,
			logic [BYTE_W-1:0] lo, logic [BYTE_W-1:0] hi, logic on);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		frame_id <= fid;
		data_low <= lo;
		data_high <= hi;
		override_on <= on;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Holds the sender off until every pending command has come back, then lets the
	// pipeline settle so that a register write finds the block idle.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (3) @(posedge clk);
	endtask

	// Write enable stays high across consecutive writes; the caller lowers it.
	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		sb.write_reg(index, data);
		@(posedge clk);
	endtask

	task automatic apply_config(cmw_pkg::cfg_t c);
		write_reg(cmw_pkg::REG_DUTY_ID, CFG_DATA_W'(c.duty_frame_id));
		write_reg(cmw_pkg::REG_FREE_ID, CFG_DATA_W'(c.free_frame_id));
		write_reg(cmw_pkg::REG_MAX_IVL, c.link_timeout);
		write_reg(cmw_pkg::REG_LED_PRESENT, CFG_DATA_W'(c.led_present));
		write_reg(cmw_pkg::REG_LED_LINKED, c.led_period_linked);
		write_reg(cmw_pkg::REG_LED_LOST, c.led_period_lost);
		cfg_we <= 1'b0;
	endtask

	// Short timeouts and LED periods keep the watchdog and the LED busy within a few items.
	// Now and then both identifiers are the same, so the duty frame must take precedence.
	function automatic cmw_pkg::cfg_t random_config();
		cmw_pkg::cfg_t c;
		c.duty_frame_id = FRAME_ID_W'($urandom);
		c.free_frame_id = ($urandom_range(9) == 0) ? c.duty_frame_id : FRAME_ID_W'($urandom);
		c.link_timeout = PERIOD_W'($urandom_range(24));
		c.led_present = 1'($urandom);
		c.led_period_linked = PERIOD_W'($urandom_range(1, 12));
		c.led_period_lost = PERIOD_W'($urandom_range(1, 12));
		return c;
	endfunction

	// Most frames carry one of the configured identifiers; the rest are noise. Frames that
	// match neither identifier change nothing and are not counted as real traffic.
	task automatic send_random_item(output bit counted);
		int                    pick;
		logic [KIND_W-1:0]     k;
		logic [FRAME_ID_W-1:0] fid;
		pick = $urandom_range(99);
		if (pick < 45)
			k = cmw_pkg::KIND_TICK;
		else if (pick < 80)
			k = cmw_pkg::KIND_FRAME;
		else if (pick < 90)
			k = cmw_pkg::KIND_MOTOR_O;
		else
			k = cmw_pkg::KIND_LED_O;
		case ($urandom_range(2))
			0: fid = sb.regs.duty_frame_id;
			1: fid = sb.regs.free_frame_id;
			default: fid = FRAME_ID_W'($urandom);
		endcase
		counted = (k != cmw_pkg::KIND_FRAME) || (fid == sb.regs.duty_frame_id) ||
			(fid == sb.regs.free_frame_id);
		push_item(k, fid, BYTE_W'($urandom), BYTE_W'($urandom), ($urandom_range(99) < 35));
	endtask

	// Random traffic with bursts of ticks, so that the link times out and the LED switches to
	// its lost period. Halfway through, the sender waits until every command has come back.
	task automatic run_phase(int n_items);
		int  count;
		int  burst;
		bit  counted;
		bit  held_off;
		count = 0;
		held_off = 1'b0;
		while (count < n_items) begin
			if (!held_off && count >= n_items / 2) begin
				drain_results();
				held_off = 1'b1;
			end
			if ($urandom_range(99) < 8) begin
				burst = $urandom_range(1, 30);
				repeat (burst)
					push_item(cmw_pkg::KIND_TICK, FRAME_ID_W'($urandom), BYTE_W'($urandom),
						BYTE_W'($urandom), 1'($urandom));
				count += burst;
			end else begin
				send_random_item(counted);
				if (counted)
					count++;
			end
		end
		drain_results();
	endtask

	initial begin
		cmw_pkg::cfg_t c;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: default duty and free identifiers, LED absent.
		push_item(cmw_pkg::KIND_TICK, '0, '0, '0, 1'b0);
		push_item(cmw_pkg::KIND_FRAME, cmw_pkg::RST_DUTY_ID, 8'h34, 8'h12, 1'b0);
		push_item(cmw_pkg::KIND_FRAME, cmw_pkg::RST_FREE_ID, 8'h00, 8'h00, 1'b1);
		drain_results();

		// Distinct identifiers, a very short timeout and fast LED periods.
		apply_config('{duty_frame_id: 11'h2A5, free_frame_id: 11'h15A, link_timeout: 16'd2,
			led_present: 1'b1, led_period_linked: 16'd2, led_period_lost: 16'd1});
		// Duty decode at full scale both ways, negative zero and plain zero.
		push_item(cmw_pkg::KIND_FRAME, 11'h2A5, 8'hFF, 8'h7F, 1'b0);
		push_item(cmw_pkg::KIND_FRAME, 11'h2A5, 8'hFF, 8'hFF, 1'b1);
		push_item(cmw_pkg::KIND_FRAME, 11'h2A5, 8'h00, 8'h80, 1'b0);
		push_item(cmw_pkg::KIND_FRAME, 11'h2A5, 8'h00, 8'h00, 1'b0);
		push_item(cmw_pkg::KIND_FRAME, 11'h15A, 8'hAA, 8'h55, 1'b0);
		// A frame matching neither identifier must not refresh the link.
		push_item(cmw_pkg::KIND_FRAME, 11'h7FF, 8'h12, 8'h34, 1'b0);
		// Ticks run the link into timeout, which forces zero duty and the lost LED period.
		repeat (3) push_item(cmw_pkg::KIND_TICK, 11'h7FF, 8'hFF, 8'hFF, 1'b1);
		// While the motor is held, neither the timeout nor a duty frame reaches it.
		push_item(cmw_pkg::KIND_MOTOR_O, '0, '0, '0, 1'b1);
		push_item(cmw_pkg::KIND_TICK, '0, '0, '0, 1'b0);
		push_item(cmw_pkg::KIND_FRAME, 11'h2A5, 8'h34, 8'h92, 1'b0);
		// Releasing the override always commands free, even when it is already released.
		push_item(cmw_pkg::KIND_MOTOR_O, '0, '0, '0, 1'b0);
		push_item(cmw_pkg::KIND_MOTOR_O, '0, '0, '0, 1'b0);
		// The LED level freezes during an override; ending an inactive one changes nothing.
		push_item(cmw_pkg::KIND_LED_O, '0, '0, '0, 1'b1);
		push_item(cmw_pkg::KIND_TICK, '0, '0, '0, 1'b0);
		push_item(cmw_pkg::KIND_LED_O, '0, '0, '0, 1'b0);
		push_item(cmw_pkg::KIND_LED_O, '0, '0, '0, 1'b0);
		push_item(cmw_pkg::KIND_TICK, '0, '0, '0, 1'b0);
		drain_results();

		// Both identifiers equal: the frame counts as a duty frame. No LED: its override is ignored.
		apply_config('{duty_frame_id: 11'h3C3, free_frame_id: 11'h3C3, link_timeout: 16'd1,
			led_present: 1'b0, led_period_linked: 16'd3, led_period_lost: 16'd2});
		push_item(cmw_pkg::KIND_FRAME, 11'h3C3, 8'h01, 8'h81, 1'b0);
		push_item(cmw_pkg::KIND_LED_O, '0, '0, '0, 1'b1);
		repeat (2) push_item(cmw_pkg::KIND_TICK, '0, '0, '0, 1'b0);
		drain_results();

		// Random segments: the first two under the register extremes, the rest with random
		// settings. Pairs of segments stall the receiver, then idle the sender, then neither.
		for (int seg = 0; seg < 6; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 14;
					recv_idle_pct = 88;
				end
				1: begin
					send_idle_pct = 88;
					recv_idle_pct = 14;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (seg == 0)
				c = '{duty_frame_id: 11'h000, free_frame_id: 11'h7FF, link_timeout: 16'd0,
					led_present: 1'b1, led_period_linked: 16'd1, led_period_lost: 16'd1};
			else if (seg == 1)
				c = '{duty_frame_id: 11'h7FF, free_frame_id: 11'h000, link_timeout: 16'hFFFF,
					led_present: 1'b1, led_period_linked: 16'hFFFF, led_period_lost: 16'hFFFF};
			else
				c = random_config();
			apply_config(c);
			run_phase(PHASE_ITEMS);
		end

		// Every command has come back; any stray result is caught before the final verdict.
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- can_motor_command_watchdog_unit.f -----
sv/cmw_pkg.sv
sv/cmw_cfg_regs.sv
sv/can_motor_command_watchdog_unit.sv
dv/tb_can_motor_command_watchdog_unit.sv
